// File: design/gpa_pkg.sv
`default_nettype none
package gpa_pkg;

  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned PC_W        = 4;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned LEG_COUNT_DEF = 6;
  localparam int unsigned SQRT_STEPS  = 16;
  localparam int unsigned PHASE_SHIFT = 11;
  localparam logic [15:0] MAG_ONE     = 16'd32768;
  localparam logic [15:0] RATE_RESET  = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIT_MODE   = 4'd0,
    REG_RATE_TRIPOD = 4'd1,
    REG_RATE_WAVE   = 4'd2,
    REG_RATE_RIPPLE = 4'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_TRIPOD   = 3'd0,
    MODE_OBSTACLE = 3'd1,
    MODE_WAVE     = 3'd2,
    MODE_RIPPLE   = 3'd3
  } gait_mode_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_Z,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_CLAMP,
    OP_MUL_DT,
    OP_MUL_RATE,
    OP_LEG_INIT,
    OP_LEG_UPD,
    OP_EMIT,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_WAIT_IN,
    C_LOOP_SQRT,
    C_LOOP_LEG
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic start;
    logic sqrt_done;
    logic leg_last;
    logic stall;
  } seq_status_t;

  function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
    ucw_t w;
    case (pc)
      4'd0:    w = '{op: OP_IDLE,      cond: C_WAIT_IN,   target: 4'd0};
      4'd1:    w = '{op: OP_SQ_X,      cond: C_NEXT,      target: 4'd0};
      4'd2:    w = '{op: OP_SQ_Y,      cond: C_NEXT,      target: 4'd0};
      4'd3:    w = '{op: OP_SQ_Z,      cond: C_NEXT,      target: 4'd0};
      4'd4:    w = '{op: OP_SQRT_INIT, cond: C_NEXT,      target: 4'd0};
      4'd5:    w = '{op: OP_SQRT_STEP, cond: C_LOOP_SQRT, target: 4'd5};
      4'd6:    w = '{op: OP_CLAMP,     cond: C_NEXT,      target: 4'd0};
      4'd7:    w = '{op: OP_MUL_DT,    cond: C_NEXT,      target: 4'd0};
      4'd8:    w = '{op: OP_MUL_RATE,  cond: C_NEXT,      target: 4'd0};
      4'd9:    w = '{op: OP_LEG_INIT,  cond: C_NEXT,      target: 4'd0};
      4'd10:   w = '{op: OP_LEG_UPD,   cond: C_NEXT,      target: 4'd0};
      4'd11:   w = '{op: OP_EMIT,      cond: C_LOOP_LEG,  target: 4'd10};
      default: w = '{op: OP_NOP,       cond: C_GOTO,      target: 4'd0};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: design/gpa_seq.sv
`default_nettype none
module gpa_seq
  import gpa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire seq_status_t status,
  output ucw_t             ctl
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [PC_W-1:0] pc_inc;

  assign ctl    = ucode_rom(pc_r);
  assign pc_inc = pc_r + PC_W'(1);

  always_comb begin
    case (ctl.cond)
      C_NEXT:      pc_nxt = pc_inc;
      C_GOTO:      pc_nxt = ctl.target;
      C_WAIT_IN:   pc_nxt = status.start ? pc_inc : pc_r;
      C_LOOP_SQRT: pc_nxt = status.sqrt_done ? pc_inc : ctl.target;
      C_LOOP_LEG: begin
        if (status.stall) begin
          pc_nxt = pc_r;
        end else begin
          pc_nxt = status.leg_last ? pc_inc : ctl.target;
        end
      end
      default:     pc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/gpa_dp.sv
`default_nettype none
module gpa_dp
  import gpa_pkg::*;
#(
  parameter int unsigned LEG_COUNT = LEG_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ucw_t               ctl,
  input  wire logic               start,
  input  wire logic signed [15:0] vel_x,
  input  wire logic signed [15:0] vel_y,
  input  wire logic signed [15:0] yaw_rate,
  input  wire logic [15:0]        elapsed,
  input  wire logic [15:0]        rate,
  input  wire logic               out_ready,
  output seq_status_t             status,
  output logic                    out_valid,
  output logic [2:0]              out_leg_index,
  output logic [31:0]             out_leg_phase_out,
  output logic                    out_last_leg
);

  localparam int unsigned LEG_W = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;
  localparam int unsigned NRES  = (LEG_COUNT < MAX_RESULTS) ? LEG_COUNT : MAX_RESULTS;
  localparam int unsigned CNT_W = $clog2(SQRT_STEPS);

  logic signed [15:0] vx_r, vy_r, vz_r;
  logic [15:0]        dt_r;
  logic [31:0]        acc_r, x_r, res_r, bit_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [15:0]        mag_r;
  logic [47:0]        prod_r;
  logic [31:0]        dphase_r;
  logic [LEG_W-1:0]   leg_r;
  logic [31:0]        phase_r [LEG_COUNT];

  logic               out_valid_r;
  logic [2:0]         out_idx_r;
  logic [31:0]        out_phase_r;
  logic               out_last_r;

  logic signed [15:0] sq_in;
  logic signed [31:0] sq;
  logic [31:0]        trial;
  logic               need, busy, stall, load;

  always_comb begin
    case (ctl.op)
      OP_SQ_X: sq_in = vx_r;
      OP_SQ_Y: sq_in = vy_r;
      default: sq_in = vz_r;
    endcase
  end

  assign sq    = 32'(sq_in) * 32'(sq_in);
  assign trial = res_r + bit_r;

  assign need  = (ctl.op == OP_EMIT) && (32'(leg_r) < NRES);
  assign busy  = out_valid_r && !out_ready;
  assign stall = need && busy;
  assign load  = need && !busy;

  assign status.start     = start;
  assign status.sqrt_done = (cnt_r == CNT_W'(SQRT_STEPS - 1));
  assign status.leg_last  = (leg_r == LEG_W'(LEG_COUNT - 1));
  assign status.stall     = stall;

  assign out_valid         = out_valid_r;
  assign out_leg_index     = out_idx_r;
  assign out_leg_phase_out = out_phase_r;
  assign out_last_leg      = out_last_r;

  always_ff @(posedge clk) begin
    if (start) begin
      vx_r <= vel_x;
      vy_r <= vel_y;
      vz_r <= yaw_rate;
      dt_r <= elapsed;
    end
    case (ctl.op)
      OP_SQ_X: acc_r <= sq;
      OP_SQ_Y, OP_SQ_Z: acc_r <= acc_r + sq;
      OP_SQRT_INIT: begin
        x_r   <= acc_r;
        res_r <= '0;
        bit_r <= 32'h4000_0000;
        cnt_r <= '0;
      end
      OP_SQRT_STEP: begin
        if (x_r >= trial) begin
          x_r   <= x_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      OP_CLAMP: mag_r <= (res_r > 32'(MAG_ONE)) ? MAG_ONE : res_r[15:0];
      OP_MUL_DT: prod_r <= 48'(mag_r) * 48'(dt_r);
      OP_MUL_RATE: prod_r <= 48'(prod_r[31:0]) * 48'(rate);
      OP_LEG_INIT: dphase_r <= prod_r[PHASE_SHIFT +: 32];
      default: ;
    endcase
    if (load) begin
      out_idx_r   <= 3'(leg_r);
      out_phase_r <= phase_r[leg_r];
      out_last_r  <= (leg_r == LEG_W'(NRES - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leg_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEG_COUNT; i++) begin
        phase_r[i] <= '0;
      end
    end else begin
      case (ctl.op)
        OP_LEG_INIT: leg_r <= '0;
        OP_LEG_UPD:  phase_r[leg_r] <= phase_r[leg_r] + dphase_r;
        OP_EMIT: begin
          if (!stall) begin
            leg_r <= leg_r + LEG_W'(1);
          end
        end
        default: ;
      endcase
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/gait_phase_advance_core.sv
`default_nettype none
// Gait phase advance core.
// Input channel (in_*): one control tick per transfer with three Q1.15
// velocity components and the elapsed time in 2^-20 s units. Each tick
// advances every leg phase by the same increment and returns one result
// per leg (up to six), leg 0 first, with out_last_leg set on the last one.
// Configuration channel (cfg_*): gait mode and three Q8.8 stride rates,
// always ready; write only while the core is idle.
// Timing: a microcoded sequencer runs one control word per cycle, except
// while it waits at its idle step for a tick or holds at its emit step.
// The next tick can be taken only after every leg has been processed and
// the sequencer has returned to its idle step; in_ready is high only while
// the sequencer sits at its idle step.
// Results leave through an output register; when it is still full and
// out_ready is low the sequencer holds at its emit step until it frees up.
// Reset clears all leg phases to zero, sets mode tripod and all rates
// to 1.0 stride per second.
module gait_phase_advance_core
  import gpa_pkg::*;
#(
  parameter int unsigned LEG_COUNT = LEG_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [15:0]    in_vel_x,
  input  wire logic signed [15:0]    in_vel_y,
  input  wire logic signed [15:0]    in_yaw_rate,
  input  wire logic [15:0]           in_elapsed,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 out_leg_index,
  output logic [31:0]                out_leg_phase_out,
  output logic                       out_last_leg,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [2:0]  gait_mode_r;
  logic [15:0] rate_tripod_r, rate_wave_r, rate_ripple_r;
  logic [15:0] rate;
  ucw_t        ctl;
  seq_status_t status;
  logic        start;

  assign cfg_ready = 1'b1;
  assign in_ready  = (ctl.op == OP_IDLE);
  assign start     = in_valid && in_ready;

  always_comb begin
    case (gait_mode_r)
      MODE_TRIPOD, MODE_OBSTACLE: rate = rate_tripod_r;
      MODE_RIPPLE:                rate = rate_ripple_r;
      default:                    rate = rate_wave_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gait_mode_r   <= MODE_TRIPOD;
      rate_tripod_r <= RATE_RESET;
      rate_wave_r   <= RATE_RESET;
      rate_ripple_r <= RATE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIT_MODE:   gait_mode_r   <= cfg_data[2:0];
        REG_RATE_TRIPOD: rate_tripod_r <= cfg_data;
        REG_RATE_WAVE:   rate_wave_r   <= cfg_data;
        REG_RATE_RIPPLE: rate_ripple_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gpa_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl)
  );

  gpa_dp #(
    .LEG_COUNT (LEG_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .start             (start),
    .vel_x             (in_vel_x),
    .vel_y             (in_vel_y),
    .yaw_rate          (in_yaw_rate),
    .elapsed           (in_elapsed),
    .rate              (rate),
    .out_ready         (out_ready),
    .status            (status),
    .out_valid         (out_valid),
    .out_leg_index     (out_leg_index),
    .out_leg_phase_out (out_leg_phase_out),
    .out_last_leg      (out_last_leg)
  );

endmodule
`default_nettype wire
